/* sv/two_channel_block_rms_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef TWO_CHANNEL_BLOCK_RMS_CORE_DEFINES_SVH
`define TWO_CHANNEL_BLOCK_RMS_CORE_DEFINES_SVH

// Check a property on every rising clock edge, skipped while reset is low.
`define TCBRMS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define TCBRMS_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/tcbrms_pkg.sv */
`default_nettype none
package tcbrms_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int RMS_W     = 12;
    localparam int COUNT_W   = 16;
    localparam int SUM_W     = 40;
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_STEPS  = SUM_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [SAMPLE_W-1:0] MID_SCALE = SAMPLE_W'(2048);
    localparam logic [COUNT_W-1:0]  COUNT_RST = COUNT_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CH0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CH1 = CFG_IDX_W'(1);

endpackage
`default_nettype wire

/* sv/two_channel_block_rms_core.sv */
// Channel    | Handshake                  | Payload
// sample in  | i_valid / o_ready          | i_sample
// result out | o_valid / i_ready          | o_channel, o_rms
// config     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A sample that is added to its channel's sum passes through accept, square and add.
// A sample that closes a block passes through accept, 40 steps of the restoring
// divider, 20 steps of the square root and the load of the output register.
// Divider and square root share one 23-bit subtractor, which does one step per cycle.
// A zero count skips both and goes from accept to the output load. o_ready is high only while idle.
// Reset (i_rst_n low, synchronous) clears sums, counts, the channel toggle and
// sets both configured counts to 256. A result waits in the output register while new
// samples are taken; a second result holds until the first is taken.
`default_nettype none
module two_channel_block_rms_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  [tcbrms_pkg::SAMPLE_W-1:0]       i_sample,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic                                  o_channel,
    output logic [tcbrms_pkg::RMS_W-1:0]          o_rms,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [tcbrms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [tcbrms_pkg::COUNT_W-1:0]        i_cfg_data
);
    import tcbrms_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQR  = 6'b000010,
        S_ACC  = 6'b000100,
        S_DIV  = 6'b001000,
        S_ROOT = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_cfg [2];
    logic [COUNT_W-1:0]   r_cnt [2];
    logic [SUM_W-1:0]     r_sum [2];
    logic                 r_chan;
    logic                 r_ch;
    logic [SAMPLE_W-1:0]  r_mag;
    logic [SQ_W-1:0]      r_sq;
    logic [SUM_W-1:0]     r_work;
    logic [COUNT_W-1:0]   r_dvs;
    logic [REM_W-1:0]     r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [STEP_W-1:0]    r_step;
    logic                 r_out_valid;
    logic                 r_out_ch;
    logic [RMS_W-1:0]     r_out_rms;

    logic [COUNT_W-1:0]   cur_req;
    logic                 below;
    logic [SAMPLE_W-1:0]  mag;
    logic [REM_W-1:0]     sub_a, sub_b;
    logic [REM_W:0]       sub_diff;
    logic                 sub_ge;
    logic                 last_div, last_root, out_free;

    assign cur_req   = r_chan ? r_cfg[1] : r_cfg[0];
    assign below     = r_cnt[r_chan] < cur_req;
    // channel 0 measures distance from mid-scale, channel 1 the raw sample
    assign mag       = r_chan ? i_sample :
                       (i_sample[SAMPLE_W-1] ? {1'b0, i_sample[SAMPLE_W-2:0]}
                                             : MID_SCALE - i_sample);
    assign last_div  = r_step == STEP_W'(DIV_STEPS - 1);
    assign last_root = r_step == STEP_W'(ROOT_STEPS - 1);
    assign out_free  = !r_out_valid || i_ready;

    // shared trial subtractor: divider remainder or root remainder
    always_comb begin
        if (r_state == S_ROOT) begin
            sub_a = {1'b0, r_rem[REM_W-4:0], r_work[SUM_W-1 -: 2]};
            sub_b = {1'b0, r_root, 2'b01};
        end else begin
            sub_a = {(REM_W-COUNT_W-1)'(0), r_rem[COUNT_W-1:0], r_work[SUM_W-1]};
            sub_b = {(REM_W-COUNT_W)'(0), r_dvs};
        end
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_diff[REM_W];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (below)
                        n_state = S_SQR;
                    else if (cur_req == '0)
                        n_state = S_DONE;
                    else
                        n_state = S_DIV;
                end
            end
            S_SQR:  n_state = S_ACC;
            S_ACC:  n_state = S_IDLE;
            S_DIV:  if (last_div) n_state = S_ROOT;
            S_ROOT: if (last_root) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg[0]    <= COUNT_RST;
            r_cfg[1]    <= COUNT_RST;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_chan      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_COUNT_CH0: r_cfg[0] <= i_cfg_data;
                    CFG_COUNT_CH1: r_cfg[1] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_chan <= ~r_chan;
                        r_ch   <= r_chan;
                        if (below) begin
                            r_mag          <= mag;
                            r_cnt[r_chan]  <= r_cnt[r_chan] + 1'b1;
                        end else begin
                            // latch the block, then clear it for the next one
                            r_work        <= r_sum[r_chan];
                            r_dvs         <= cur_req;
                            r_cnt[r_chan] <= '0;
                            r_sum[r_chan] <= '0;
                            r_rem         <= '0;
                            r_root        <= '0;
                            r_step        <= '0;
                        end
                    end
                end
                S_SQR: r_sq <= r_mag * r_mag;
                S_ACC: r_sum[r_ch] <= r_sum[r_ch] + {(SUM_W-SQ_W)'(0), r_sq};
                S_DIV: begin
                    r_work <= {r_work[SUM_W-2:0], sub_ge};
                    if (last_div) begin
                        r_rem  <= '0;
                        r_step <= '0;
                    end else begin
                        r_rem  <= sub_ge ? sub_diff[REM_W-1:0] : sub_a;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_ROOT: begin
                    r_work <= {r_work[SUM_W-3:0], 2'b00};
                    r_rem  <= sub_ge ? sub_diff[REM_W-1:0] : sub_a;
                    r_root <= {r_root[ROOT_W-2:0], sub_ge};
                    r_step <= r_step + 1'b1;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ch    <= r_ch;
                        // saturate roots that outgrow the result field
                        r_out_rms   <= (|r_root[ROOT_W-1:RMS_W]) ? '1 : r_root[RMS_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_ready     = r_state == S_IDLE;
    assign o_valid     = r_out_valid;
    assign o_channel   = r_out_ch;
    assign o_rms       = r_out_rms;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

/* sv/tcbrms_chk.sv */
`default_nettype none
`include "two_channel_block_rms_core_defines.svh"
module tcbrms_chk (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_valid,
    input wire                               o_ready,
    input wire                               o_valid,
    input wire                               i_ready,
    input wire                               o_channel,
    input wire [tcbrms_pkg::RMS_W-1:0]       o_rms,
    input wire                               o_cfg_ready
);
    // every accepted item keeps the block busy in the cycle after it
    `TCBRMS_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "input ready right after an accepted item")

    // a new result shows up only out of a busy cycle
    `TCBRMS_ASSERT_RST(a_result_from_work, i_clk, i_rst_n, $rose(o_valid) |-> $past(!o_ready), "result appeared without work in progress")

    // a stalled result holds
    `TCBRMS_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_rms) && $stable(o_channel)), "stalled result changed")

    // no result while in reset, config always taken
    `TCBRMS_ASSERT(a_reset_quiet, i_clk, (!i_rst_n) |=> (!o_valid && o_cfg_ready), "result valid after reset")

endmodule

bind two_channel_block_rms_core tcbrms_chk u_tcbrms_chk (.*);
`default_nettype wire
